### rtl/matrix_inverse_3x3_assert.svh
// assertion macros for the 3x3 matrix inverse block
// expects clk and rst_n in the scope where the macros are used
`ifndef MATRIX_INVERSE_3X3_ASSERT_SVH
`define MATRIX_INVERSE_3X3_ASSERT_SVH
`ifndef SYNTH
`define MIV_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("matrix_inverse_3x3: check failed");
`define MIV_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("matrix_inverse_3x3: implication failed");
`else
`define MIV_ASSERT(lbl, prop)
`define MIV_ASSERT_IMPL(lbl, ante, cons)
`endif
`endif

### rtl/miv_pkg.sv
// shared types and constants for the 3x3 matrix inverse block
// no dependencies
`default_nettype none

package miv_pkg;

    localparam int WORD_W = 32;
    localparam int FRAC_W = 16;
    localparam int THR_W  = WORD_W - 1;

    typedef logic [3:0] idx_t;

    // element indexes (row-major) of the two products that form each cofactor
    localparam idx_t COF_IDX [9][4] = '{
        '{4'd4, 4'd8, 4'd5, 4'd7}, '{4'd2, 4'd7, 4'd1, 4'd8}, '{4'd1, 4'd5, 4'd2, 4'd4},
        '{4'd5, 4'd6, 4'd3, 4'd8}, '{4'd0, 4'd8, 4'd2, 4'd6}, '{4'd2, 4'd3, 4'd0, 4'd5},
        '{4'd3, 4'd7, 4'd4, 4'd6}, '{4'd1, 4'd6, 4'd0, 4'd7}, '{4'd0, 4'd4, 4'd1, 4'd3}
    };

    typedef struct packed {
        logic signed [WORD_W-1:0] a11;
        logic signed [WORD_W-1:0] a12;
        logic signed [WORD_W-1:0] a13;
        logic signed [WORD_W-1:0] a21;
        logic signed [WORD_W-1:0] a22;
        logic signed [WORD_W-1:0] a23;
        logic signed [WORD_W-1:0] a31;
        logic signed [WORD_W-1:0] a32;
        logic signed [WORD_W-1:0] a33;
    } miv_in_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] b11;
        logic signed [WORD_W-1:0] b12;
        logic signed [WORD_W-1:0] b13;
        logic signed [WORD_W-1:0] b21;
        logic signed [WORD_W-1:0] b22;
        logic signed [WORD_W-1:0] b23;
        logic signed [WORD_W-1:0] b31;
        logic signed [WORD_W-1:0] b32;
        logic signed [WORD_W-1:0] b33;
        logic                     singular;
        logic                     saturated;
    } miv_out_t;

    // per-item flags that ride alongside the divider lanes
    typedef struct packed {
        logic       sing;
        logic [8:0] neg;
    } miv_side_t;

endpackage

`default_nettype wire

### rtl/matrix_inverse_3x3.sv
// top level of the 3x3 matrix inverse by the adjugate, signed fixed point
// uses miv_pkg, miv_cof_lane, miv_div_lane and matrix_inverse_3x3_assert.svh
//
//  channel   | direction | handshake            | payload
//  ----------+-----------+----------------------+---------------------------
//  in        | input     | in_valid / in_stall  | in_data  (a11..a33)
//  out       | output    | out_valid / out_stall| out_data (b11..b33, flags)
//  cfg       | input     | cfg_write            | cfg_data (singular_threshold)
//
// one matrix per cycle while the pipeline is not frozen; out_valid for a transfer in rises once it has
//   passed the cofactor lanes and the divider lanes that resolve one quotient bit per stage
// the whole pipeline freezes while out_valid is held by out_stall, and
//   in_stall mirrors that freeze
// reset clears the valid pipeline and sets the threshold to 1
`default_nettype none
`include "matrix_inverse_3x3_assert.svh"

module matrix_inverse_3x3 #(
    parameter int FRAC_BITS = miv_pkg::FRAC_W
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  miv_pkg::miv_in_t           in_data,
    output logic                       out_valid,
    input  logic                       out_stall,
    output miv_pkg::miv_out_t          out_data,
    input  logic                       cfg_write,
    input  logic [miv_pkg::THR_W-1:0]  cfg_data
);

    import miv_pkg::*;

    localparam int W   = WORD_W;
    localparam int CW  = 2*W + 1;             // cofactor width
    localparam int DW  = 3*W + 3;             // determinant width
    localparam int SH  = 2*FRAC_BITS;         // threshold alignment
    localparam int NSH = SH + 1;              // numerator shift, extra bit for rounding
    localparam int NW  = ((CW + NSH > DW) ? CW + NSH : DW) + 1;
    localparam int DEW = DW + 1;
    localparam int QB  = W + 1;               // quotient bits kept
    localparam int LAT = QB + 8;

    localparam logic [QB-1:0]       LIM_NEG = QB'(1) << (W-1);
    localparam logic [QB-1:0]       LIM_POS = LIM_NEG - QB'(1);
    localparam logic signed [W-1:0] SMAX    = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] SMIN    = {1'b1, {(W-1){1'b0}}};

    // global pipeline advance
    logic en;
    assign en       = !(out_valid && out_stall);
    assign in_stall = !en;

    logic [LAT-1:0] vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[LAT-2:0], in_valid};
    end

    assign out_valid = vld_reg[LAT-1];

    // threshold register
    logic [THR_W-1:0] thr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            thr_reg <= THR_W'(1);
        else if (cfg_write)
            thr_reg <= cfg_data;
    end

    // element fan-out, row-major
    logic signed [W-1:0] a_in [9];

    assign a_in[0] = in_data.a11;
    assign a_in[1] = in_data.a12;
    assign a_in[2] = in_data.a13;
    assign a_in[3] = in_data.a21;
    assign a_in[4] = in_data.a22;
    assign a_in[5] = in_data.a23;
    assign a_in[6] = in_data.a31;
    assign a_in[7] = in_data.a32;
    assign a_in[8] = in_data.a33;

    // nine cofactor lanes, each with product and difference registers
    logic signed [CW-1:0] cof_w [9];

    for (genvar i = 0; i < 9; i++)
    begin : g_cof
        miv_cof_lane #(
            .W (W)
        ) u_cof (
            .clk (clk),
            .en  (en),
            .x0  (a_in[COF_IDX[i][0]]),
            .x1  (a_in[COF_IDX[i][1]]),
            .y0  (a_in[COF_IDX[i][2]]),
            .y1  (a_in[COF_IDX[i][3]]),
            .cof (cof_w[i])
        );
    end

    // first row delayed to meet the cofactors
    logic signed [W-1:0] a1_d0_reg [3];
    logic signed [W-1:0] a1_d1_reg [3];

    // determinant: a1j times the cofactor split into a low and a high half
    logic signed [CW-1:0] dlo_reg  [3];
    logic signed [CW-1:0] dhi_reg  [3];
    logic signed [DW-1:0] term_reg [3];
    logic signed [DW-1:0] det_reg;
    logic signed [CW-1:0] cd2_reg  [9];
    logic signed [CW-1:0] cd3_reg  [9];
    logic signed [CW-1:0] cd4_reg  [9];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < 3; j++)
            begin
                a1_d0_reg[j] <= a_in[j];
                a1_d1_reg[j] <= a1_d0_reg[j];
                dlo_reg[j]   <= a1_d1_reg[j] * $signed({1'b0, cof_w[3*j][W-1:0]});
                dhi_reg[j]   <= a1_d1_reg[j] * $signed(cof_w[3*j][CW-1:W]);
                term_reg[j]  <= (DW'(dhi_reg[j]) <<< W) + DW'(dlo_reg[j]);
            end
            det_reg <= term_reg[0] + term_reg[1] + term_reg[2];
            cd2_reg <= cof_w;
            cd3_reg <= cd2_reg;
            cd4_reg <= cd3_reg;
        end
    end

    // magnitudes, singular test, rounded numerators
    logic            det_neg;
    logic [DW-1:0]   det_mag;
    logic [DW-1:0]   thr_ext;
    logic [CW-1:0]   c_mag   [9];
    logic [NW-1:0]   num_next [9];
    miv_side_t       side_next;

    always_comb
    begin
        det_neg        = det_reg[DW-1];
        det_mag        = det_neg ? DW'(-det_reg) : DW'(det_reg);
        thr_ext        = DW'(thr_reg) << SH;
        side_next.sing = det_mag <= thr_ext;
        for (int i = 0; i < 9; i++)
        begin
            c_mag[i]         = cd4_reg[i][CW-1] ? CW'(-cd4_reg[i]) : CW'(cd4_reg[i]);
            num_next[i]      = (NW'(c_mag[i]) << NSH) + NW'(det_mag);
            side_next.neg[i] = cd4_reg[i][CW-1] ^ det_neg;
        end
    end

    logic [NW-1:0]  num_reg [9];
    logic [DEW-1:0] den_reg;
    miv_side_t      side_reg [QB+2];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_reg     <= num_next;
            den_reg     <= {det_mag, 1'b0};
            side_reg[0] <= side_next;
            for (int k = 0; k < QB+1; k++)
                side_reg[k+1] <= side_reg[k];
        end
    end

    // nine divider lanes
    logic [QB-1:0] quo_w [9];
    logic          ovf_w [9];

    for (genvar i = 0; i < 9; i++)
    begin : g_div
        miv_div_lane #(
            .NW  (NW),
            .DEW (DEW),
            .QB  (QB)
        ) u_div (
            .clk (clk),
            .en  (en),
            .num (num_reg[i]),
            .den (den_reg),
            .quo (quo_w[i]),
            .ovf (ovf_w[i])
        );
    end

    // merge: sign, clipping, singular override
    miv_side_t           side_out;
    logic signed [W-1:0] res  [9];
    logic [8:0]          clip;
    logic [QB-1:0]       qneg [9];
    miv_out_t            out_next;

    assign side_out = side_reg[QB+1];

    always_comb
    begin
        for (int i = 0; i < 9; i++)
        begin
            qneg[i] = -quo_w[i];
            if (side_out.neg[i])
            begin
                clip[i] = ovf_w[i] || (quo_w[i] > LIM_NEG);
                res[i]  = clip[i] ? SMIN : $signed(qneg[i][W-1:0]);
            end
            else
            begin
                clip[i] = ovf_w[i] || (quo_w[i] > LIM_POS);
                res[i]  = clip[i] ? SMAX : $signed(quo_w[i][W-1:0]);
            end
            if (side_out.sing)
            begin
                clip[i] = 1'b0;
                res[i]  = '0;
            end
        end
        out_next.b11       = res[0];
        out_next.b12       = res[1];
        out_next.b13       = res[2];
        out_next.b21       = res[3];
        out_next.b22       = res[4];
        out_next.b23       = res[5];
        out_next.b31       = res[6];
        out_next.b32       = res[7];
        out_next.b33       = res[8];
        out_next.singular  = side_out.sing;
        out_next.saturated = |clip;
    end

    miv_out_t out_reg;

    always_ff @(posedge clk)
    begin
        if (en)
            out_reg <= out_next;
    end

    assign out_data = out_reg;

    // helpers for the checks below
    logic out_zero;
    logic out_clip;

    always_comb
    begin
        out_zero = (out_data.b11 == '0) && (out_data.b12 == '0) && (out_data.b13 == '0)
                && (out_data.b21 == '0) && (out_data.b22 == '0) && (out_data.b23 == '0)
                && (out_data.b31 == '0) && (out_data.b32 == '0) && (out_data.b33 == '0);
        out_clip = (out_data.b11 == SMAX) || (out_data.b11 == SMIN)
                || (out_data.b12 == SMAX) || (out_data.b12 == SMIN)
                || (out_data.b13 == SMAX) || (out_data.b13 == SMIN)
                || (out_data.b21 == SMAX) || (out_data.b21 == SMIN)
                || (out_data.b22 == SMAX) || (out_data.b22 == SMIN)
                || (out_data.b23 == SMAX) || (out_data.b23 == SMIN)
                || (out_data.b31 == SMAX) || (out_data.b31 == SMIN)
                || (out_data.b32 == SMAX) || (out_data.b32 == SMIN)
                || (out_data.b33 == SMAX) || (out_data.b33 == SMIN);
    end

    `MIV_ASSERT(a_stall_freeze, in_stall == (out_valid && out_stall))
    `MIV_ASSERT_IMPL(a_sing_zero, out_valid && out_data.singular, out_zero && !out_data.saturated)
    `MIV_ASSERT_IMPL(a_sat_clip, out_valid && out_data.saturated, out_clip)

endmodule

`default_nettype wire

### rtl/miv_cof_lane.sv
// one cofactor lane: two element products and their difference
// depends on nothing but its parameters
`default_nettype none

module miv_cof_lane #(
    parameter int W = 32
) (
    input  logic                  clk,
    input  logic                  en,
    input  logic signed [W-1:0]   x0,
    input  logic signed [W-1:0]   x1,
    input  logic signed [W-1:0]   y0,
    input  logic signed [W-1:0]   y1,
    output logic signed [2*W:0]   cof
);

    logic signed [2*W-1:0] p_reg;
    logic signed [2*W-1:0] q_reg;
    logic signed [2*W:0]   cof_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg   <= x0 * x1;
            q_reg   <= y0 * y1;
            cof_reg <= (2*W+1)'(p_reg) - (2*W+1)'(q_reg);
        end
    end

    assign cof = cof_reg;

endmodule

`default_nettype wire

### rtl/miv_div_lane.sv
// one divider lane: pipelined restoring division, one quotient bit per stage
// depends on nothing but its parameters
`default_nettype none

module miv_div_lane #(
    parameter int NW  = 133,
    parameter int DEW = 100,
    parameter int QB  = 33
) (
    input  logic           clk,
    input  logic           en,
    input  logic [NW-1:0]  num,
    input  logic [DEW-1:0] den,
    output logic [QB-1:0]  quo,
    output logic           ovf
);

    logic [DEW-1:0] rem_reg [QB];
    logic [DEW-1:0] den_reg [QB];
    logic [QB-1:0]  low_reg [QB];
    logic [QB-1:0]  q_reg   [QB+1];
    logic           ovf_reg [QB+1];

    // quotient would not fit in QB bits
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ovf_reg[0] <= (num >> QB) >= NW'(den);
            rem_reg[0] <= DEW'(num >> QB);
            low_reg[0] <= num[QB-1:0];
            den_reg[0] <= den;
            q_reg[0]   <= '0;
        end
    end

    for (genvar k = 0; k < QB; k++)
    begin : g_stage
        logic [DEW:0] trial;
        logic [DEW:0] diff;
        logic         take;

        always_comb
        begin
            trial = {rem_reg[k], low_reg[k][QB-1-k]};
            diff  = trial - {1'b0, den_reg[k]};
            take  = trial >= {1'b0, den_reg[k]};
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                q_reg[k+1]   <= q_reg[k] | (QB'(take) << (QB-1-k));
                ovf_reg[k+1] <= ovf_reg[k];
            end
        end

        if (k < QB-1)
        begin : g_fwd
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k+1] <= take ? diff[DEW-1:0] : trial[DEW-1:0];
                    den_reg[k+1] <= den_reg[k];
                    low_reg[k+1] <= low_reg[k];
                end
            end
        end
    end

    assign quo = q_reg[QB];
    assign ovf = ovf_reg[QB];

endmodule

`default_nettype wire
